@@ hw/rtl/ptc_pkg.sv @@
// ============================================================================
// ptc_pkg
// Shared types and constants of the prefix tree counter.
// ============================================================================
package ptc_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int SYM_W      = 8;
    localparam int COUNT_W    = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [NODE_W-1:0]  ROOT_NODE  = '0;
    localparam logic [NODE_W-1:0]  NO_LINK    = '0;
    localparam logic [NODE_W-1:0]  LAST_NODE  = NODE_W'(NODE_COUNT - 1);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_COUNT  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // One pool entry as held in the node memory
    typedef struct packed {
        logic [SYM_W-1:0]   symbol;
        logic [NODE_W-1:0]  child;
        logic [NODE_W-1:0]  sibling;
        logic [COUNT_W-1:0] count;
    } node_t;

    localparam int NODE_BITS = $bits(node_t);

    typedef struct packed {
        logic               rd_en;
        logic [NODE_W-1:0]  rd_addr;
        logic               wr_en;
        logic [NODE_W-1:0]  wr_addr;
        node_t              wr_data;
    } mem_cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0] occurrences;
        logic               status;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_CMP,
        S_NOHIT,
        S_LINK,
        S_DONE
    } state_t;

endpackage

@@ hw/rtl/ptc_channels.sv @@
// ============================================================================
// ptc_channels
// Valid/ready channel interfaces for byte requests and count responses.
// ============================================================================
interface ptc_req_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [ptc_pkg::SYM_W-1:0] symbol;
    logic                      last;

    modport source (output valid, output kind, output symbol, output last, input ready);
    modport sink   (input valid, input kind, input symbol, input last, output ready);
endinterface

interface ptc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ptc_pkg::COUNT_W-1:0] occurrences;
    logic                        status;

    modport source (output valid, output occurrences, output status, input ready);
    modport sink   (input valid, input occurrences, input status, output ready);
endinterface

@@ hw/rtl/prefix_tree_counter.sv @@
// ============================================================================
// prefix_tree_counter
// Byte-string trie with per-string occurrence counters in a node memory.
// ============================================================================
// Usage: strings enter on req one byte per transaction (kind 0 insert,
// kind 1 count query, last marks the final byte). A byte with last set gives
// one transaction on rsp: occurrences and status (1 = node pool full during
// the insert, string not counted); other bytes give none.
// Timing: req.ready is high only while the walker is idle. For each byte the
// walker reads the first child, compares siblings in the node memory (one
// per cycle, registered read), then adds a no-match step when no sibling
// matches and a link step when an insert allocates a node.
// A byte of a string that already missed or overflowed skips the walk.
// The result reaches rsp in the cycle after the byte completes.
// A new byte is taken only once the walker has finished the last one.
// Reset: the trie is emptied at once (root link and node count are flops),
// no clearing pass; the first byte is accepted right after reset.
// Stall: rsp is a one-entry output register; the next byte is taken while a
// result waits, and a further result holds the walker until rsp frees up.
// ============================================================================
module prefix_tree_counter (
    input  logic      clk,
    input  logic      rst_n,
    ptc_req_if.sink   req,
    ptc_rsp_if.source rsp
);

    ptc_pkg::mem_cmd_t mem_cmd;
    ptc_pkg::node_t    rd_data;
    ptc_pkg::result_t  res;
    logic              res_valid;
    logic              slot_free;

    logic                        out_valid_reg;
    logic [ptc_pkg::COUNT_W-1:0] occ_reg;
    logic                        status_reg;

    ptc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .mem_cmd   (mem_cmd),
        .rd_data   (rd_data),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res)
    );

    ptc_ram #(
        .WIDTH (ptc_pkg::NODE_BITS),
        .DEPTH (ptc_pkg::NODE_COUNT)
    ) u_nodes (
        .clk     (clk),
        .wr_en   (mem_cmd.wr_en),
        .wr_addr (mem_cmd.wr_addr),
        .wr_data (mem_cmd.wr_data),
        .rd_en   (mem_cmd.rd_en),
        .rd_addr (mem_cmd.rd_addr),
        .rd_data (rd_data)
    );

    assign slot_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && res_valid)
        begin
            occ_reg    <= res.occurrences;
            status_reg <= res.status;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.occurrences = occ_reg;
    assign rsp.status      = status_reg;

endmodule

@@ hw/rtl/ptc_ram.sv @@
// ============================================================================
// ptc_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ============================================================================
module ptc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/ptc_ctrl.sv @@
// ============================================================================
// ptc_ctrl
// Trie walker: sibling-list search, node allocation and count update.
// ============================================================================
module ptc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    ptc_req_if.sink              req,
    output ptc_pkg::mem_cmd_t    mem_cmd,
    input  ptc_pkg::node_t       rd_data,
    input  logic                 slot_free,
    output logic                 res_valid,
    output ptc_pkg::result_t     res
);

    ptc_pkg::state_t state_reg, state_next;

    // control state
    logic [ptc_pkg::NODE_W-1:0] cursor_reg, cursor_next;
    logic [ptc_pkg::NODE_W-1:0] root_child_reg, root_child_next;
    logic [ptc_pkg::NODE_W-1:0] nodes_used_reg, nodes_used_next;
    logic                       miss_reg, miss_next;
    logic                       full_reg, full_next;

    // payload
    logic                       kind_reg, kind_next;
    logic [ptc_pkg::SYM_W-1:0]  sym_reg, sym_next;
    logic                       last_reg, last_next;
    logic [ptc_pkg::NODE_W-1:0] link_reg, link_next;
    ptc_pkg::node_t             cur_word_reg, cur_word_next;

    logic [ptc_pkg::NODE_W-1:0]  cursor_child;
    logic [ptc_pkg::NODE_W-1:0]  fresh;
    ptc_pkg::node_t              fresh_word;
    ptc_pkg::node_t              link_word;
    ptc_pkg::node_t              count_word;
    logic [ptc_pkg::COUNT_W-1:0] inc_count;
    logic                        accept;
    logic                        hit;
    logic                        pool_full;
    logic                        finish;

    // The cursor's own entry is cached, so only sibling nodes are read.
    assign cursor_child = (cursor_reg == ptc_pkg::ROOT_NODE) ? root_child_reg
                                                             : cur_word_reg.child;
    assign fresh     = nodes_used_reg + 1'b1;
    assign pool_full = (nodes_used_reg == ptc_pkg::LAST_NODE);
    assign hit       = (rd_data.symbol == sym_reg);
    assign accept    = req.valid && req.ready;
    assign finish    = (state_reg == ptc_pkg::S_DONE) && last_reg && slot_free;
    assign inc_count = (cur_word_reg.count == ptc_pkg::COUNT_MAX) ? cur_word_reg.count
                                                                  : cur_word_reg.count + 1'b1;

    always_comb
    begin
        fresh_word         = '0;
        fresh_word.symbol  = sym_reg;
        fresh_word.child   = ptc_pkg::NO_LINK;
        fresh_word.sibling = cursor_child;
        link_word          = cur_word_reg;
        link_word.child    = fresh;
        count_word         = cur_word_reg;
        count_word.count   = inc_count;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (miss_reg || full_reg) ? ptc_pkg::S_DONE : ptc_pkg::S_LOOK;
                end
            end
            ptc_pkg::S_LOOK:
            begin
                state_next = (cursor_child == ptc_pkg::NO_LINK) ? ptc_pkg::S_NOHIT
                                                                : ptc_pkg::S_CMP;
            end
            ptc_pkg::S_CMP:
            begin
                if (hit)
                begin
                    state_next = ptc_pkg::S_DONE;
                end
                else if (rd_data.sibling == ptc_pkg::NO_LINK)
                begin
                    state_next = ptc_pkg::S_NOHIT;
                end
            end
            ptc_pkg::S_NOHIT:
            begin
                state_next = (kind_reg == ptc_pkg::KIND_COUNT || pool_full) ? ptc_pkg::S_DONE
                                                                            : ptc_pkg::S_LINK;
            end
            ptc_pkg::S_LINK:
            begin
                state_next = ptc_pkg::S_DONE;
            end
            ptc_pkg::S_DONE:
            begin
                if (!last_reg || slot_free)
                begin
                    state_next = ptc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ptc_pkg::S_IDLE;
            end
        endcase
    end

    // outputs: memory commands, handshake, result
    always_comb
    begin
        mem_cmd   = '0;
        req.ready = 1'b0;
        res_valid = 1'b0;
        res.status      = full_reg ? ptc_pkg::STATUS_FULL : ptc_pkg::STATUS_OK;
        res.occurrences = '0;
        if (!miss_reg && !full_reg)
        begin
            res.occurrences = (kind_reg == ptc_pkg::KIND_INSERT) ? inc_count
                                                                 : cur_word_reg.count;
        end
        case (state_reg)
            ptc_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
            end
            ptc_pkg::S_LOOK:
            begin
                mem_cmd.rd_en   = (cursor_child != ptc_pkg::NO_LINK);
                mem_cmd.rd_addr = cursor_child;
            end
            ptc_pkg::S_CMP:
            begin
                // chase the next sibling right away
                mem_cmd.rd_en   = !hit && (rd_data.sibling != ptc_pkg::NO_LINK);
                mem_cmd.rd_addr = rd_data.sibling;
            end
            ptc_pkg::S_NOHIT:
            begin
                mem_cmd.wr_en   = (kind_reg == ptc_pkg::KIND_INSERT) && !pool_full;
                mem_cmd.wr_addr = fresh;
                mem_cmd.wr_data = fresh_word;
            end
            ptc_pkg::S_LINK:
            begin
                mem_cmd.wr_en   = (cursor_reg != ptc_pkg::ROOT_NODE);
                mem_cmd.wr_addr = cursor_reg;
                mem_cmd.wr_data = link_word;
            end
            ptc_pkg::S_DONE:
            begin
                res_valid       = finish;
                mem_cmd.wr_en   = finish && !miss_reg && !full_reg
                                  && (kind_reg == ptc_pkg::KIND_INSERT);
                mem_cmd.wr_addr = cursor_reg;
                mem_cmd.wr_data = count_word;
            end
            default:
            begin
                mem_cmd = '0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        cursor_next     = cursor_reg;
        root_child_next = root_child_reg;
        nodes_used_next = nodes_used_reg;
        miss_next       = miss_reg;
        full_next       = full_reg;
        kind_next       = kind_reg;
        sym_next        = sym_reg;
        last_next       = last_reg;
        link_next       = link_reg;
        cur_word_next   = cur_word_reg;
        case (state_reg)
            ptc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    kind_next = req.kind;
                    sym_next  = req.symbol;
                    last_next = req.last;
                end
            end
            ptc_pkg::S_LOOK:
            begin
                link_next = cursor_child;
            end
            ptc_pkg::S_CMP:
            begin
                if (hit)
                begin
                    cursor_next   = link_reg;
                    cur_word_next = rd_data;
                end
                else
                begin
                    link_next = rd_data.sibling;
                end
            end
            ptc_pkg::S_NOHIT:
            begin
                if (kind_reg == ptc_pkg::KIND_COUNT)
                begin
                    miss_next = 1'b1;
                end
                else if (pool_full)
                begin
                    full_next = 1'b1;
                end
            end
            ptc_pkg::S_LINK:
            begin
                if (cursor_reg == ptc_pkg::ROOT_NODE)
                begin
                    root_child_next = fresh;
                end
                nodes_used_next = fresh;
                cursor_next     = fresh;
                cur_word_next   = fresh_word;
            end
            ptc_pkg::S_DONE:
            begin
                if (finish)
                begin
                    cursor_next = ptc_pkg::ROOT_NODE;
                    miss_next   = 1'b0;
                    full_next   = 1'b0;
                end
            end
            default:
            begin
                cursor_next = cursor_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ptc_pkg::S_IDLE;
            cursor_reg     <= ptc_pkg::ROOT_NODE;
            root_child_reg <= ptc_pkg::NO_LINK;
            nodes_used_reg <= '0;
            miss_reg       <= 1'b0;
            full_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            root_child_reg <= root_child_next;
            nodes_used_reg <= nodes_used_next;
            miss_reg       <= miss_next;
            full_reg       <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        sym_reg      <= sym_next;
        last_reg     <= last_next;
        link_reg     <= link_next;
        cur_word_reg <= cur_word_next;
    end

    // ------------------------------------------------------------------------
    a_pool_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (nodes_used_reg >= $past(nodes_used_reg)))
        else $error("node pool count went backwards");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(miss_reg && full_reg))
        else $error("miss and full flags both set");

    a_no_root_read: assert property (@(posedge clk) disable iff (!rst_n)
        mem_cmd.rd_en |-> (mem_cmd.rd_addr != ptc_pkg::ROOT_NODE))
        else $error("read of the root entry");

    a_alloc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_cmd.wr_en && state_reg == ptc_pkg::S_NOHIT) |-> !pool_full)
        else $error("allocation beyond the node pool");

    a_result_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (slot_free && last_reg))
        else $error("result issued without a free output slot");

endmodule
